// ===== src/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared codes and types of the I2C target byte memory: bus event kinds,
// register map and the command word from the sequencer to the byte store.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // Bus event kinds carried on the item channel
  localparam logic [1:0] MODE_BYTE = 2'd0;  // byte received from the master
  localparam logic [1:0] MODE_READ = 2'd1;  // master reads one byte
  localparam logic [1:0] MODE_STOP = 2'd2;  // stop or repeated start

  // Register map: word index taken from paddr[2]
  localparam int          PADDR_W        = 3;
  localparam logic        REG_TIME_ADDR  = 1'b0;
  localparam logic [7:0]  TIME_ADDR_RST  = 8'hf0;

  // Timestamp word length in bytes
  localparam int          STAMP_BYTES    = 4;

  // Byte store port enables
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

// ===== src/i2c_target_byte_memory.sv =====
// ----------------------------------------------------------------------------
// i2c_target_byte_memory
// Target side of an I2C byte memory with an auto-incrementing pointer.
//
// Each input item is one bus event: a received byte, a read request or a
// stop/restart. After a stop the first ADDR_PHASE_BYTES received bytes are
// the address; the last one becomes the pointer. Later bytes are written at
// the pointer, reads return the byte at the pointer, and both advance it.
// A read at the timestamp address first stores in_time_us there big-endian.
//
// Timing: a received byte, stop or unused code is taken while idle. A read
// issues the store read on accept, and the fetch state then moves the read
// data into the output register. A read at the timestamp address first
// writes the four time word bytes in the stamp state, through the single
// write port of the byte store. After reset a clearing pass zeroes the
// store with in_stall high; register writes are taken meanwhile. A stalled
// result stays in the output register; the next item is still accepted,
// and only a further read waits in fetch until the register is free.
// ----------------------------------------------------------------------------
module i2c_target_byte_memory #(
  parameter int MEM_BYTES        = 256,
  parameter int ADDR_PHASE_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // event items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_rx_byte,
  input  logic [31:0]                   in_time_us,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_tx_byte,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import i2cbm_pkg::*;

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  logic [7:0]    time_addr;
  mem_cmd_t      mem_cmd;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  i2cbm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .time_addr (time_addr)
  );

  i2cbm_mem #(
    .DEPTH (MEM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  i2cbm_ctrl #(
    .MEM_BYTES        (MEM_BYTES),
    .ADDR_PHASE_BYTES (ADDR_PHASE_BYTES),
    .AW               (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_rx_byte  (in_rx_byte),
    .in_time_us  (in_time_us),
    .time_addr   (time_addr),
    .mem_cmd     (mem_cmd),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte)
  );

endmodule

// ===== src/i2cbm_regs.sv =====
// ----------------------------------------------------------------------------
// i2cbm_regs
// Configuration register bank behind the APB-style port. Holds the address
// of the timestamp word.
// ----------------------------------------------------------------------------
module i2cbm_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [7:0]                    time_addr
);
  import i2cbm_pkg::*;

  logic [7:0] time_addr_r;
  logic [7:0] time_addr_nxt;
  logic       wr_hit;

  // Decode a completed write to the timestamp address register
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TIME_ADDR);

  always_comb begin
    time_addr_nxt = time_addr_r;
    if (wr_hit) begin
      time_addr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_addr_r <= TIME_ADDR_RST;
    end else begin
      time_addr_r <= time_addr_nxt;
    end
  end

  // Return the register on its address, zero elsewhere
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TIME_ADDR) begin
      prdata = {24'd0, time_addr_r};
    end
  end

  assign pready    = 1'b1;
  assign time_addr = time_addr_r;

endmodule

// ===== src/i2cbm_mem.sv =====
// ----------------------------------------------------------------------------
// i2cbm_mem
// Byte store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module i2cbm_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  i2cbm_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]       waddr,
  input  logic [7:0]          wdata,
  input  logic [AW-1:0]       raddr,
  output logic [7:0]          rdata
);
  import i2cbm_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write on request
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read on request; hold the last data otherwise
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/i2cbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cbm_ctrl
// Event sequencer: address phase counting, pointer update, timestamp store,
// read issue and the result register. Also runs the clearing pass of the
// byte store after reset.
// ----------------------------------------------------------------------------
module i2cbm_ctrl #(
  parameter int MEM_BYTES        = 256,
  parameter int ADDR_PHASE_BYTES = 4,
  parameter int AW               = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_rx_byte,
  input  logic [31:0]         in_time_us,
  // configuration
  input  logic [7:0]          time_addr,
  // byte store
  output i2cbm_pkg::mem_cmd_t mem_cmd,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [7:0]          mem_rdata,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_tx_byte
);
  import i2cbm_pkg::*;

  localparam int CW = $clog2(ADDR_PHASE_BYTES + 1);
  localparam int SW = $clog2(STAMP_BYTES);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_STAMP = 4'b0100,
    ST_FETCH = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;

  logic          accept;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] rx_addr;
  logic [AW:0]   stamp_sum;
  logic [AW-1:0] stamp_addr;
  logic          time_hit;
  logic          out_free;

  // Reduce a received address byte into the store range
  function automatic logic [7:0] rx_wrap(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    for (int k = 3; k >= 0; k--) begin
      if (int'(r) >= (MEM_BYTES << k)) begin
        r = 8'(int'(r) - (MEM_BYTES << k));
      end
    end
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign ptr_inc  = (ptr_r == AW'(MEM_BYTES - 1)) ? '0 : ptr_r + AW'(1);
  assign rx_addr  = AW'(rx_wrap(in_rx_byte));
  assign time_hit = (32'(ptr_r) == 32'(time_addr));
  assign out_free = !out_valid_r || !out_stall;

  // Address of the timestamp byte being written, wrapped at the store end
  assign stamp_sum  = {1'b0, ptr_r} + (AW + 1)'(cnt_r);
  assign stamp_addr = (stamp_sum >= (AW + 1)'(MEM_BYTES))
                    ? AW'(stamp_sum - (AW + 1)'(MEM_BYTES))
                    : AW'(stamp_sum);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    stamp_nxt     = stamp_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    mem_cmd       = '0;
    mem_waddr     = ptr_r;
    mem_wdata     = in_rx_byte;
    mem_raddr     = ptr_r;

    // Drop a result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Zero one entry per cycle
        mem_cmd.wr_en = 1'b1;
        mem_waddr     = clr_r;
        mem_wdata     = 8'd0;
        clr_nxt       = clr_r + AW'(1);
        if (clr_r == AW'(MEM_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_BYTE: begin
              if (left_r != '0) begin
                // Address phase: keep only the last byte
                left_nxt = left_r - CW'(1);
                if (left_r == CW'(1)) begin
                  ptr_nxt = rx_addr;
                end
              end else begin
                mem_cmd.wr_en = 1'b1;
                ptr_nxt       = ptr_inc;
              end
            end
            MODE_READ: begin
              if (time_hit) begin
                // Store the time word first, then read
                stamp_nxt = in_time_us;
                cnt_nxt   = '0;
                state_nxt = ST_STAMP;
              end else begin
                mem_cmd.rd_en = 1'b1;
                ptr_nxt       = ptr_inc;
                state_nxt     = ST_FETCH;
              end
            end
            MODE_STOP: begin
              left_nxt = CW'(ADDR_PHASE_BYTES);
            end
            default: begin
            end
          endcase
        end
      end
      ST_STAMP: begin
        // Write the time word most significant byte first
        mem_cmd.wr_en = 1'b1;
        mem_waddr     = stamp_addr;
        mem_wdata     = stamp_r[31:24];
        stamp_nxt     = {stamp_r[23:0], 8'd0};
        cnt_nxt       = cnt_r + SW'(1);
        if (cnt_r == SW'(STAMP_BYTES - 1)) begin
          mem_cmd.rd_en = 1'b1;
          ptr_nxt       = ptr_inc;
          state_nxt     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // Move read data into the result register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = mem_rdata;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      left_r      <= CW'(ADDR_PHASE_BYTES);
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    stamp_r    <= stamp_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;

endmodule

// ===== tb/i2c_target_byte_memory_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_target_byte_memory_tb
// Self-checking bench for the I2C target byte memory. A driver offers bus
// event items from a queue in bursts with gaps. A shadow copy of the byte
// store, pointer and address phase counter predicts every read. A monitor
// stalls the result channel on a pattern of its own and compares each
// returned byte with the oldest prediction. The timestamp address is
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_target_byte_memory_tb;
  import i2cbm_pkg::*;

  localparam int         MEM_BYTES    = 256;
  localparam int         ADDR_BYTES   = 4;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         PHASE_ITEMS  = 90;

  typedef struct {
    logic        drain;   // pause marker: wait until all reads came back
    logic [1:0]  mode;
    logic [7:0]  rx;
    logic [31:0] t;
  } bus_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_STOP;
  logic [7:0]  in_rx_byte = 8'd0;
  logic [31:0] in_time_us = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and prediction stores
  bus_event_t  pending_events[$];
  logic [7:0]  expected_tx_bytes[$];
  bus_event_t  cur_event;
  int          event_count = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // Shadow state of the block
  logic [7:0]  shadow_mem [MEM_BYTES];
  logic [7:0]  shadow_ptr;
  logic [2:0]  shadow_addr_left;
  logic [7:0]  shadow_time_addr;

  // Driver pacing
  int          burst_left = 0;
  int          gap_left = 0;

  // Receiver pacing
  int          stall_style = 0;
  int          seg_left = 0;
  int          holdoff_left = 0;
  int          hold_count = 0;
  int          results_seen = 0;

  i2c_target_byte_memory #(
    .MEM_BYTES       (MEM_BYTES),
    .ADDR_PHASE_BYTES(ADDR_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .in_time_us (in_time_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tx_byte(out_tx_byte),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one accepted bus event to the shadow state; queue the read byte
  task automatic apply_bus_event(input bus_event_t ev);
    logic [7:0] a;
    case (ev.mode)
      MODE_BYTE: begin
        if (shadow_addr_left != 3'd0) begin
          shadow_addr_left = shadow_addr_left - 3'd1;
          if (shadow_addr_left == 3'd0) shadow_ptr = ev.rx;
        end else begin
          shadow_mem[shadow_ptr] = ev.rx;
          shadow_ptr = shadow_ptr + 8'd1;
        end
      end
      MODE_READ: begin
        if (shadow_ptr == shadow_time_addr) begin
          a = shadow_ptr;
          shadow_mem[a] = ev.t[31:24];
          a = a + 8'd1;
          shadow_mem[a] = ev.t[23:16];
          a = a + 8'd1;
          shadow_mem[a] = ev.t[15:8];
          a = a + 8'd1;
          shadow_mem[a] = ev.t[7:0];
        end
        expected_tx_bytes.push_back(shadow_mem[shadow_ptr]);
        shadow_ptr = shadow_ptr + 8'd1;
      end
      MODE_STOP: shadow_addr_left = 3'(ADDR_BYTES);
      default: ;
    endcase
  endtask

  // Driver: offer items in bursts, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'd0;
      shadow_ptr = 8'd0;
      shadow_addr_left = 3'(ADDR_BYTES);
      shadow_time_addr = TIME_ADDR_RST;
    end else begin
      if (in_valid && !in_stall) apply_bus_event(cur_event);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0 && pending_events[0].drain) begin
          in_valid <= 1'b0;
          if (expected_tx_bytes.size() == 0) void'(pending_events.pop_front());
        end else if (pending_events.size() > 0) begin
          cur_event = pending_events.pop_front();
          in_valid <= 1'b1;
          in_mode <= cur_event.mode;
          in_rx_byte <= cur_event.rx;
          in_time_us <= cur_event.t;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check returned bytes and drive the stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_tx_bytes.size() == 0) begin
          $display("%0t: tx_byte expected none, got %02h", $time, out_tx_byte);
          mismatch_count++;
        end else begin
          if (out_tx_byte !== expected_tx_bytes[0]) begin
            $display("%0t: tx_byte expected %02h, got %02h", $time,
                     expected_tx_bytes[0], out_tx_byte);
            mismatch_count++;
          end
          void'(expected_tx_bytes.pop_front());
        end
      end
      // long hold-off while the sender keeps offering
      if (holdoff_left == 0 && hold_count < 2 &&
          results_seen >= (hold_count == 0 ? 30 : 200) &&
          pending_events.size() > 40) begin
        holdoff_left = 250;
        hold_count++;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_style = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 60);
        end else begin
          seg_left--;
        end
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("i2c_target_byte_memory: mismatch");
      $finish;
    end
  end

  task automatic push_event(input logic [1:0] m, input logic [7:0] rx,
                            input logic [31:0] t);
    bus_event_t ev;
    ev.drain = 1'b0;
    ev.mode = m;
    ev.rx = rx;
    ev.t = t;
    pending_events.push_back(ev);
    if (m != MODE_UNUSED) event_count++;
  endtask

  task automatic push_drain_marker();
    bus_event_t ev;
    ev.drain = 1'b1;
    ev.mode = MODE_UNUSED;
    ev.rx = 8'd0;
    ev.t = 32'd0;
    pending_events.push_back(ev);
  endtask

  // Stop followed by a full address phase ending in a
  task automatic push_address(input logic [7:0] a);
    logic [7:0] hi;
    push_event(MODE_STOP, 8'd0, 32'd0);
    for (int i = 0; i < ADDR_BYTES - 1; i++) begin
      hi = 8'($urandom);
      push_event(MODE_BYTE, hi, 32'd0);
    end
    push_event(MODE_BYTE, a, 32'd0);
  endtask

  // Extremes, wrap, timestamp read, broken address phase, unused code
  task automatic add_directed_events();
    push_event(MODE_UNUSED, 8'hff, 32'hffff_ffff);
    push_event(MODE_READ, 8'h00, 32'h0000_0000);   // read in address phase
    push_event(MODE_STOP, 8'h00, 32'h0000_0000);
    for (int i = 0; i < ADDR_BYTES; i++) push_event(MODE_BYTE, 8'hff, 32'd0);
    push_event(MODE_BYTE, 8'ha5, 32'd0);           // write at the top
    push_event(MODE_BYTE, 8'h00, 32'd0);           // pointer wrapped
    push_event(MODE_STOP, 8'h00, 32'd0);
    push_event(MODE_BYTE, 8'h12, 32'd0);
    push_event(MODE_BYTE, 8'h34, 32'd0);
    push_event(MODE_STOP, 8'h00, 32'd0);           // cut address phase
    push_event(MODE_BYTE, 8'h00, 32'd0);
    push_event(MODE_BYTE, 8'h00, 32'd0);
    push_event(MODE_BYTE, 8'h00, 32'd0);
    push_event(MODE_BYTE, TIME_ADDR_RST, 32'd0);
    push_event(MODE_READ, 8'h00, 32'hffff_ffff);   // timestamp stored
    push_event(MODE_UNUSED, 8'h5a, 32'h1234_5678);
    push_event(MODE_READ, 8'hff, 32'h0000_0000);
    push_event(MODE_READ, 8'h00, 32'hdead_beef);
    push_event(MODE_READ, 8'h00, 32'h0000_0000);
    push_event(MODE_STOP, 8'h00, 32'd0);
    push_event(MODE_READ, 8'h00, 32'h0000_0000);
  endtask

  // Mostly well-formed transfers, some broken ones and some noise
  task automatic add_random_events(input logic [7:0] tw, input int target);
    int         start;
    int         kind;
    int         n;
    bit         marked;
    logic [7:0] a;
    logic [7:0] b;
    logic [1:0] m;
    start = event_count;
    marked = 1'b0;
    while (event_count - start < target) begin
      if (!marked && event_count - start >= target / 2) begin
        push_drain_marker();
        marked = 1'b1;
      end
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: a = tw;
        1: a = 8'($urandom_range(252, 255));
        2: a = tw - 8'd1;
        default: a = 8'($urandom);
      endcase
      if (kind <= 5) begin
        push_address(a);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom);
          if ($urandom_range(0, 1) == 0) push_event(MODE_READ, b, $urandom);
          else push_event(MODE_BYTE, b, $urandom);
        end
      end else if (kind <= 7) begin
        // write a run, then read it back
        n = $urandom_range(1, 6);
        push_address(a);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom);
          push_event(MODE_BYTE, b, $urandom);
        end
        push_address(a);
        for (int i = 0; i < n; i++) push_event(MODE_READ, 8'd0, $urandom);
      end else if (kind == 8) begin
        push_event(MODE_STOP, 8'd0, $urandom);
        n = $urandom_range(0, ADDR_BYTES - 1);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom);
          push_event(MODE_BYTE, b, $urandom);
        end
        if ($urandom_range(0, 1) == 0) push_event(MODE_READ, 8'd0, $urandom);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          m = 2'($urandom_range(0, 3));
          b = 8'($urandom);
          push_event(m, b, $urandom);
        end
      end
    end
  endtask

  task automatic write_time_word_address(input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TIME_ADDR, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_time_addr = value;
  endtask

  // Wait until every item is taken and every read came back
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_events.size() != 0 || in_valid || expected_tx_bytes.size() != 0);
  endtask

  // Sequence: reset, directed items, then phases with new timestamp addresses
  initial begin
    logic [7:0] cfg_values [6];
    cfg_values[0] = 8'd0;
    cfg_values[1] = 8'd252;
    cfg_values[2] = 8'h83;
    cfg_values[3] = TIME_ADDR_RST;
    cfg_values[4] = 8'($urandom_range(0, 252));
    cfg_values[5] = 8'h7c;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;
    add_directed_events();
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_time_word_address(cfg_values[i]);
      #1;
      add_random_events(cfg_values[i], (i == 5) ? PHASE_ITEMS / 2 : PHASE_ITEMS);
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_tx_bytes.size() == 0) begin
      $display("i2c_target_byte_memory: match");
    end else begin
      $display("i2c_target_byte_memory: mismatch");
    end
    $finish;
  end

endmodule
